### hw/rtl/twims_pkg.sv
// Shared types and constants of the two-wire master transfer sequencer.
`timescale 1ns / 1ps

package twims_pkg;

    // Default buffer depth and the widest buffer address the depth range allows
    localparam int BUF_DEPTH_DEF = 16;
    localparam int MEM_ADDR_W    = 8;

    // Request kinds
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_EVENT = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // Control words
    localparam logic [7:0] CTRL_START   = 8'hA4;
    localparam logic [7:0] CTRL_GO_NACK = 8'h84;
    localparam logic [7:0] CTRL_GO_ACK  = 8'hC4;
    localparam logic [7:0] CTRL_STOP    = 8'h94;

    // Bus status codes
    localparam logic [7:0] STATUS_MASK     = 8'hF8;
    localparam logic [7:0] ST_START_SENT   = 8'h08;
    localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
    localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
    localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
    localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] buf_index;
        logic [7:0] buf_byte;
        logic [7:0] address_byte;
        logic [4:0] transfer_count;
        logic       bus_event_flag;
        logic [7:0] bus_status;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic       ctrl_write;
        logic [7:0] ctrl_value;
        logic       data_write;
        logic [7:0] data_value;
        logic       busy_res;
        logic [7:0] read_byte;
    } rsp_t;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [MEM_ADDR_W-1:0] addr;
        logic [7:0]            wdata;
    } mem_req_t;

endpackage

### hw/rtl/twims_stream_if.sv
// Valid/ready channel interface carrying one request or response payload.
`timescale 1ns / 1ps

interface twims_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/twims_buf.sv
// Data buffer: one port, write or registered read per cycle.
`timescale 1ns / 1ps

module twims_buf #(
    parameter int BUF_DEPTH = twims_pkg::BUF_DEPTH_DEF
) (
    input  logic                clk,
    input  twims_pkg::mem_req_t mem_req,
    output logic [7:0]          rd_data
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    logic [7:0]    mem [BUF_DEPTH];
    logic [AW-1:0] addr;

    assign addr = mem_req.addr[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[addr] <= mem_req.wdata;
        end
        if (mem_req.re)
        begin
            rd_data <= mem[addr];
        end
    end

endmodule

### hw/rtl/twi_master_transfer_sequencer_unit.sv
// Top level of the two-wire master transfer sequencer.
`timescale 1ns / 1ps
//
// Usage
//   req : sink channel of twims_pkg::req_t. A request is a buffer load, a
//         transfer start, a bus event (status code from the bus controller)
//         or a buffer read. Every request produces exactly one response.
//   rsp : source channel of twims_pkg::rsp_t carrying the control word,
//         transmit byte, busy flag and read-back byte for that request.
// Pipeline and throughput
//   An accepted request goes through the input register, then through the
//   decision logic into the response register, with the buffer read
//   landing in the same edge as the response register load. One request per
//   cycle is sustained while rsp.ready stays high; the single buffer port
//   serves every request kind since each touches at most one entry.
// Reset
//   rst_n clears both pipeline stages, the busy flag, the byte index, the
//   byte count and the latched slave address. Buffer contents are not
//   cleared; read only entries that were loaded or received.
// Back-pressure
//   With rsp.ready low the response register holds and the input stage can
//   still take one more request; req.ready drops only when both are full.
//
module twi_master_transfer_sequencer_unit #(
    parameter int BUF_DEPTH = twims_pkg::BUF_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    twims_stream_if.sink    req,
    twims_stream_if.source  rsp
);

    // Counter width holds 0..BUF_DEPTH; compare width covers the 5-bit count too
    localparam int CNTW = $clog2(BUF_DEPTH + 1);
    localparam int CMPW = (CNTW > 5) ? CNTW : 5;
    localparam int AW   = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    // Input stage
    logic              s1_valid_reg;
    twims_pkg::req_t   s1_item_reg;
    logic              s1_adv;
    logic              s1_fire;

    // Sequencer state
    logic [CNTW-1:0]   byte_index_reg, byte_index_next;
    logic [CNTW-1:0]   bytes_left_reg, bytes_left_next;
    logic [7:0]        slave_addr_reg, slave_addr_next;
    logic              busy_reg, busy_next;

    // Response stage
    logic              s2_valid_reg;
    logic              ctrl_write_reg, ctrl_write_next;
    logic [7:0]        ctrl_value_reg, ctrl_value_next;
    logic              data_write_reg, data_write_next;
    logic [7:0]        data_value_reg, data_value_next;
    logic              data_sel_reg, data_sel_next;
    logic              rd_sel_reg, rd_sel_next;
    logic              busy_res_reg;

    // Buffer access
    twims_pkg::mem_req_t mem_op;
    twims_pkg::mem_req_t mem_req;
    logic [7:0]          mem_q;

    // Decode helpers
    logic [7:0]        status;
    logic              bidx_ok;
    logic              cur_idx_ok;
    logic [CNTW-1:0]   idx_adv;
    logic [CNTW-1:0]   left_dec;
    logic [CNTW-1:0]   count_capped;
    logic [CNTW-1:0]   left_after_rx;

    // Handshake: advance the input stage when the response slot frees up
    assign s1_adv    = !s2_valid_reg || rsp.ready;
    assign s1_fire   = s1_valid_reg && s1_adv;
    assign req.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_item_reg <= req.payload;
        end
    end

    assign status     = s1_item_reg.bus_status & twims_pkg::STATUS_MASK;
    assign bidx_ok    = CMPW'(s1_item_reg.buf_index) < CMPW'(BUF_DEPTH);
    assign cur_idx_ok = CMPW'(byte_index_reg) < CMPW'(BUF_DEPTH);
    // Index saturates at the buffer end; count saturates at zero
    assign idx_adv    = cur_idx_ok ? (byte_index_reg + CNTW'(1)) : byte_index_reg;
    assign left_dec   = (bytes_left_reg != '0) ? (bytes_left_reg - CNTW'(1))
                                               : bytes_left_reg;
    assign count_capped = (CMPW'(s1_item_reg.transfer_count) > CMPW'(BUF_DEPTH))
                        ? CNTW'(BUF_DEPTH)
                        : CNTW'(s1_item_reg.transfer_count);
    assign left_after_rx = (status == twims_pkg::ST_MR_SLA_ACK) ? bytes_left_reg
                                                                 : left_dec;

    // Decision logic for the request in the input stage
    always_comb
    begin
        byte_index_next = byte_index_reg;
        bytes_left_next = bytes_left_reg;
        slave_addr_next = slave_addr_reg;
        busy_next       = busy_reg;
        ctrl_write_next = 1'b0;
        ctrl_value_next = '0;
        data_write_next = 1'b0;
        data_value_next = '0;
        data_sel_next   = 1'b0;
        rd_sel_next     = 1'b0;
        mem_op          = '0;

        unique case (s1_item_reg.req_type)
            twims_pkg::REQ_LOAD:
            begin
                mem_op.we    = bidx_ok;
                mem_op.addr  = twims_pkg::MEM_ADDR_W'(s1_item_reg.buf_index);
                mem_op.wdata = s1_item_reg.buf_byte;
            end
            twims_pkg::REQ_START:
            begin
                slave_addr_next = s1_item_reg.address_byte;
                bytes_left_next = count_capped;
                busy_next       = 1'b1;
                ctrl_write_next = 1'b1;
                ctrl_value_next = twims_pkg::CTRL_START;
            end
            twims_pkg::REQ_READ:
            begin
                mem_op.re   = bidx_ok;
                mem_op.addr = twims_pkg::MEM_ADDR_W'(s1_item_reg.buf_index);
                rd_sel_next = bidx_ok;
            end
            twims_pkg::REQ_EVENT:
            begin
                if (s1_item_reg.bus_event_flag)
                begin
                    case (status) inside
                        twims_pkg::ST_MR_SLA_ACK,
                        twims_pkg::ST_MR_DATA_ACK,
                        twims_pkg::ST_MR_DATA_NACK:
                        begin
                            // Store the received byte first, except on address ack
                            if (status != twims_pkg::ST_MR_SLA_ACK)
                            begin
                                mem_op.we       = cur_idx_ok;
                                mem_op.addr     = twims_pkg::MEM_ADDR_W'(
                                                      byte_index_reg[AW-1:0]);
                                mem_op.wdata    = s1_item_reg.rx_byte;
                                byte_index_next = idx_adv;
                                bytes_left_next = left_dec;
                            end
                            ctrl_write_next = 1'b1;
                            if (left_after_rx == CNTW'(1))
                            begin
                                ctrl_value_next = twims_pkg::CTRL_GO_NACK;
                            end
                            else if (left_after_rx == '0)
                            begin
                                ctrl_value_next = twims_pkg::CTRL_STOP;
                                busy_next       = 1'b0;
                            end
                            else
                            begin
                                ctrl_value_next = twims_pkg::CTRL_GO_ACK;
                            end
                        end
                        twims_pkg::ST_MT_SLA_ACK,
                        twims_pkg::ST_MT_DATA_ACK,
                        twims_pkg::ST_MT_SLA_NACK,
                        twims_pkg::ST_MT_DATA_NACK:
                        begin
                            ctrl_write_next = 1'b1;
                            // NACK drops the rest of the transfer
                            if (status == twims_pkg::ST_MT_SLA_NACK
                                || status == twims_pkg::ST_MT_DATA_NACK
                                || bytes_left_reg == '0)
                            begin
                                bytes_left_next = '0;
                                ctrl_value_next = twims_pkg::CTRL_STOP;
                                busy_next       = 1'b0;
                            end
                            else
                            begin
                                data_write_next = 1'b1;
                                data_sel_next   = cur_idx_ok;
                                mem_op.re       = cur_idx_ok;
                                mem_op.addr     = twims_pkg::MEM_ADDR_W'(
                                                      byte_index_reg[AW-1:0]);
                                ctrl_value_next = twims_pkg::CTRL_GO_NACK;
                                byte_index_next = idx_adv;
                                bytes_left_next = left_dec;
                            end
                        end
                        twims_pkg::ST_START_SENT:
                        begin
                            data_write_next = 1'b1;
                            data_value_next = slave_addr_reg;
                            ctrl_write_next = 1'b1;
                            ctrl_value_next = twims_pkg::CTRL_GO_NACK;
                            byte_index_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    // Touch the buffer only when the request really moves on
    always_comb
    begin
        mem_req    = mem_op;
        mem_req.we = mem_op.we && s1_fire;
        mem_req.re = mem_op.re && s1_fire;
    end

    twims_buf #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_buf (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (mem_q)
    );

    // Commit sequencer state with the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            bytes_left_reg <= '0;
            slave_addr_reg <= '0;
            busy_reg       <= 1'b0;
        end
        else if (s1_fire)
        begin
            byte_index_reg <= byte_index_next;
            bytes_left_reg <= bytes_left_next;
            slave_addr_reg <= slave_addr_next;
            busy_reg       <= busy_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            ctrl_write_reg <= ctrl_write_next;
            ctrl_value_reg <= ctrl_value_next;
            data_write_reg <= data_write_next;
            data_value_reg <= data_value_next;
            data_sel_reg   <= data_sel_next;
            rd_sel_reg     <= rd_sel_next;
            busy_res_reg   <= busy_next;
        end
    end

    // Response: buffer byte goes to the transmit or read-back field as selected
    assign rsp.valid = s2_valid_reg;

    always_comb
    begin
        rsp.payload            = '0;
        rsp.payload.ctrl_write = ctrl_write_reg;
        rsp.payload.ctrl_value = ctrl_value_reg;
        rsp.payload.data_write = data_write_reg;
        rsp.payload.data_value = data_sel_reg ? mem_q : data_value_reg;
        rsp.payload.busy_res   = busy_res_reg;
        rsp.payload.read_byte  = rd_sel_reg ? mem_q : 8'h00;
    end

endmodule

### hw/rtl/twims_chk.sv
// Port-level checker for the transfer sequencer, bound to the top level.
`timescale 1ns / 1ps

module twims_chk (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input twims_pkg::rsp_t rsp_payload
);

    logic       req_fire;
    logic       rsp_fire;
    logic [1:0] occ_reg, occ_next;
    logic       last_busy_reg;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;
    assign occ_next = occ_reg + 2'(req_fire) - 2'(rsp_fire);

    // Track requests in flight and the busy flag last delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            last_busy_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (rsp_fire)
            begin
                last_busy_reg <= rsp_payload.busy_res;
            end
        end
    end

    // Stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
        else $error("response changed while stalled");

    // A fresh response follows a request accepted into the input stage
    a_rsp_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_fire, 2))
        else $error("response without matching request");

    // At most two requests in flight
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= 2'd2 && (!rsp_valid || occ_reg != 2'd0))
        else $error("request/response count mismatch");

    // Busy rises only with a start control word
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire && rsp_payload.busy_res && !last_busy_reg
        |-> rsp_payload.ctrl_write && rsp_payload.ctrl_value == twims_pkg::CTRL_START)
        else $error("busy set without start");

endmodule

bind twi_master_transfer_sequencer_unit twims_chk u_twims_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);

### tb/tb.sv
// Self-checking testbench for the two-wire master transfer sequencer.
`timescale 1ns / 1ps

module tb;

    import twims_pkg::*;

    localparam int DEPTH = BUF_DEPTH_DEF;
    localparam int REQ_W = $bits(req_t);

    // One row of the directed stimulus table. The response is typed in only
    // when the check flag is set; other rows are scored by the predictor.
    typedef struct {
        req_t item;
        bit   check;
        rsp_t want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    twims_stream_if #(.payload_t(req_t)) req_if ();
    twims_stream_if #(.payload_t(rsp_t)) rsp_if ();

    twi_master_transfer_sequencer_unit #(
        .BUF_DEPTH (DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Predictor state: the sequencer as this bench believes it to be.
    logic [7:0]  seq_buf [DEPTH];
    bit [DEPTH-1:0] seq_filled;
    int unsigned seq_idx;
    int unsigned seq_left;
    logic [7:0]  seq_addr;
    bit          seq_busy;

    rsp_t expected_rsp [$];
    plan_row_t plan [$];

    int errors;
    int n_requests;
    int n_responses;
    int n_stops;
    int n_received;
    int n_sent;
    int src_idle;
    int snk_idle;

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #1000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] buf_peek(input int unsigned i);
        return (i < DEPTH) ? seq_buf[i] : 8'h00;
    endfunction

    function automatic void buf_poke(input int unsigned i, input logic [7:0] v);
        if (i < DEPTH)
        begin
            seq_buf[i]    = v;
            seq_filled[i] = 1'b1;
        end
    endfunction

    // Step the index (saturating at the buffer depth) and the count (at zero)
    function automatic void step_pointers();
        if (seq_idx < DEPTH)
            seq_idx++;
        if (seq_left > 0)
            seq_left--;
    endfunction

    // Work out the response of one request and advance the predicted state
    function automatic rsp_t sequence_step(input req_t item);
        rsp_t       o;
        logic [7:0] code;
        o    = '0;
        code = item.bus_status & STATUS_MASK;
        case (item.req_type)
            REQ_LOAD:
                buf_poke(item.buf_index, item.buf_byte);
            REQ_START:
            begin
                seq_addr     = item.address_byte;
                seq_left     = (item.transfer_count > DEPTH) ? DEPTH : item.transfer_count;
                seq_busy     = 1'b1;
                o.ctrl_write = 1'b1;
                o.ctrl_value = CTRL_START;
            end
            REQ_READ:
                o.read_byte = buf_peek(item.buf_index);
            default:
            begin
                if (item.bus_event_flag)
                begin
                    if (code == ST_MR_SLA_ACK || code == ST_MR_DATA_ACK
                        || code == ST_MR_DATA_NACK)
                    begin
                        // Receive: store the incoming byte, then pick ACK/NACK/stop
                        if (code != ST_MR_SLA_ACK)
                        begin
                            buf_poke(seq_idx, item.rx_byte);
                            step_pointers();
                        end
                        o.ctrl_write = 1'b1;
                        if (seq_left == 1)
                            o.ctrl_value = CTRL_GO_NACK;
                        else if (seq_left == 0)
                        begin
                            o.ctrl_value = CTRL_STOP;
                            seq_busy     = 1'b0;
                        end
                        else
                            o.ctrl_value = CTRL_GO_ACK;
                    end
                    else if (code == ST_MT_SLA_ACK || code == ST_MT_DATA_ACK
                             || code == ST_MT_SLA_NACK || code == ST_MT_DATA_NACK)
                    begin
                        // Transmit: a NACK drops the rest of the count
                        if (code == ST_MT_SLA_NACK || code == ST_MT_DATA_NACK)
                            seq_left = 0;
                        o.ctrl_write = 1'b1;
                        if (seq_left == 0)
                        begin
                            o.ctrl_value = CTRL_STOP;
                            seq_busy     = 1'b0;
                        end
                        else
                        begin
                            o.data_write = 1'b1;
                            o.data_value = buf_peek(seq_idx);
                            o.ctrl_value = CTRL_GO_NACK;
                            step_pointers();
                        end
                    end
                    else if (code == ST_START_SENT)
                    begin
                        o.data_write = 1'b1;
                        o.data_value = seq_addr;
                        o.ctrl_write = 1'b1;
                        o.ctrl_value = CTRL_GO_NACK;
                        seq_idx      = 0;
                    end
                end
            end
        endcase
        o.busy_res = seq_busy;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Queue the expectation, then present the request and hold it until taken
    task automatic put_item(input req_t item, input bit check, input rsp_t want);
        rsp_t guess;
        guess = sequence_step(item);
        expected_rsp.push_back(check ? want : guess);
        n_requests++;
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.payload = item;
        req_if.valid   = 1'b1;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    // Keep every buffer access on entries that hold a known byte
    task automatic issue(input req_t item, input bit check, input rsp_t want);
        req_t       fill;
        logic [7:0] code;
        code = item.bus_status & STATUS_MASK;
        if (item.req_type == REQ_READ && !seq_filled[item.buf_index])
            item.req_type = REQ_LOAD;
        if (item.req_type == REQ_EVENT && item.bus_event_flag
            && (code == ST_MT_SLA_ACK || code == ST_MT_DATA_ACK)
            && seq_left > 0 && seq_idx < DEPTH && !seq_filled[seq_idx])
        begin
            fill           = req_t'(REQ_W'({$urandom, $urandom}));
            fill.req_type  = REQ_LOAD;
            fill.buf_index = seq_idx[3:0];
            put_item(fill, 1'b0, '0);
        end
        put_item(item, check, want);
    endtask

    // Fully random request; callers overwrite the fields that matter
    function automatic req_t rand_req();
        return req_t'(REQ_W'({$urandom, $urandom}));
    endfunction

    // Bus event with random don't-care low status bits; rarely flag-clear
    function automatic req_t bus_event(input logic [7:0] code);
        req_t r;
        r                = rand_req();
        r.req_type       = REQ_EVENT;
        r.bus_event_flag = ($urandom_range(0, 19) != 0);
        r.bus_status     = code | 8'($urandom_range(0, 7));
        return r;
    endfunction

    task automatic drain_responses();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------

    always @(negedge clk)
        rsp_if.ready = ($urandom_range(0, 99) >= snk_idle);

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        rsp_t got;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = rsp_if.payload;
            n_responses++;
            if (expected_rsp.size() == 0)
            begin
                errors++;
                $display("%0t: response %h with none expected", $time, got);
            end
            else
            begin
                want = expected_rsp.pop_front();
                check_field("ctrl_write", 8'(want.ctrl_write), 8'(got.ctrl_write));
                check_field("ctrl_value", want.ctrl_value, got.ctrl_value);
                check_field("data_write", 8'(want.data_write), 8'(got.data_write));
                check_field("data_value", want.data_value, got.data_value);
                check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                check_field("read_byte", want.read_byte, got.read_byte);
                if (got.ctrl_write && got.ctrl_value == CTRL_STOP)
                    n_stops++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin
        req_t        r;
        int unsigned cnt;
        int unsigned len;
        int          phase;
        int          kind;
        bit          nack;

        errors         = 0;
        n_requests     = 0;
        n_responses    = 0;
        n_stops        = 0;
        n_received     = 0;
        n_sent         = 0;
        src_idle       = 22;
        snk_idle       = 82;
        seq_filled     = '0;
        seq_idx        = 0;
        seq_left       = 0;
        seq_addr       = 8'h00;
        seq_busy       = 1'b0;
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;

        // Directed table: req_type, buf_index, buf_byte, address_byte,
        // transfer_count, bus_event_flag, bus_status, rx_byte.
        // Flag clear: an event with the flag low leaves everything alone
        plan.push_back('{'{REQ_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b0, ST_MT_SLA_ACK, 8'h00},
                         1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00}});
        // Event while idle: a transmit ACK with nothing to send gives a stop
        plan.push_back('{'{REQ_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b1, ST_MT_SLA_ACK, 8'h00},
                         1'b1, '{1'b1, CTRL_STOP, 1'b0, 8'h00, 1'b0, 8'h00}});
        // Unknown status codes, both ends of the byte
        plan.push_back('{'{REQ_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b1, 8'h07, 8'h00},
                         1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00}});
        plan.push_back('{'{REQ_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b1, 8'hFF, 8'hFF},
                         1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00}});
        // Loads at both ends of the buffer, read back
        plan.push_back('{'{REQ_LOAD, 4'd0, 8'h00, 8'h00, 5'd0, 1'b0, 8'h00, 8'h00},
                         1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00}});
        plan.push_back('{'{REQ_LOAD, 4'd15, 8'hFF, 8'hFF, 5'd31, 1'b1, 8'hFF, 8'hFF},
                         1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00}});
        plan.push_back('{'{REQ_LOAD, 4'd1, 8'hA5, 8'h00, 5'd0, 1'b0, 8'h00, 8'h00},
                         1'b0, '0});
        plan.push_back('{'{REQ_READ, 4'd15, 8'h00, 8'h00, 5'd0, 1'b0, 8'h00, 8'h00},
                         1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'hFF}});
        plan.push_back('{'{REQ_READ, 4'd0, 8'hFF, 8'hFF, 5'd31, 1'b1, 8'hFF, 8'hFF},
                         1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00}});
        // Count too large: 31 is clamped to the buffer depth
        plan.push_back('{'{REQ_START, 4'd0, 8'h00, 8'hFF, 5'd31, 1'b0, 8'h00, 8'h00},
                         1'b1, '{1'b1, CTRL_START, 1'b0, 8'h00, 1'b1, 8'h00}});
        // Start sent, with the low status bits set to show the mask
        plan.push_back('{'{REQ_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b1, 8'h0F, 8'h00},
                         1'b1, '{1'b1, CTRL_GO_NACK, 1'b1, 8'hFF, 1'b1, 8'h00}});
        plan.push_back('{'{REQ_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b1, ST_MT_SLA_ACK, 8'h00},
                         1'b0, '0});
        plan.push_back('{'{REQ_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b1, 8'h2F, 8'h00},
                         1'b0, '0});
        // Data NACK ends the write early
        plan.push_back('{'{REQ_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b1, ST_MT_DATA_NACK, 8'h00},
                         1'b1, '{1'b1, CTRL_STOP, 1'b0, 8'h00, 1'b0, 8'h00}});
        // Two-byte read transfer
        plan.push_back('{'{REQ_START, 4'd0, 8'h00, 8'h01, 5'd2, 1'b0, 8'h00, 8'h00},
                         1'b0, '0});
        plan.push_back('{'{REQ_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b1, ST_START_SENT, 8'h00},
                         1'b0, '0});
        plan.push_back('{'{REQ_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b1, ST_MR_SLA_ACK, 8'h00},
                         1'b0, '0});
        plan.push_back('{'{REQ_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b1, ST_MR_DATA_ACK, 8'h5A},
                         1'b0, '0});
        plan.push_back('{'{REQ_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b1, ST_MR_DATA_NACK, 8'hC3},
                         1'b0, '0});
        // Receive while idle: the count stays at zero
        plan.push_back('{'{REQ_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b1, ST_MR_DATA_NACK, 8'h11},
                         1'b0, '0});
        plan.push_back('{'{REQ_READ, 4'd2, 8'h00, 8'h00, 5'd0, 1'b0, 8'h00, 8'h00},
                         1'b0, '0});
        // Zero-length read: address ACK goes straight to stop
        plan.push_back('{'{REQ_START, 4'd0, 8'h00, 8'h00, 5'd0, 1'b0, 8'h00, 8'h00},
                         1'b0, '0});
        plan.push_back('{'{REQ_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b1, ST_MR_SLA_ACK, 8'h00},
                         1'b0, '0});
        // Start while busy relatches; address NACK then stops
        plan.push_back('{'{REQ_START, 4'd0, 8'h00, 8'h80, 5'd16, 1'b0, 8'h00, 8'h00},
                         1'b0, '0});
        plan.push_back('{'{REQ_START, 4'd0, 8'h00, 8'h7E, 5'd1, 1'b0, 8'h00, 8'h00},
                         1'b0, '0});
        plan.push_back('{'{REQ_EVENT, 4'd0, 8'h00, 8'h00, 5'd0, 1'b1, ST_MT_SLA_NACK, 8'h00},
                         1'b1, '{1'b1, CTRL_STOP, 1'b0, 8'h00, 1'b0, 8'h00}});

        // Hold reset, then release it on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
            issue(plan[i].item, plan[i].check, plan[i].want);

        // Random transfers in three idling phases
        phase = 0;
        drain_responses();
        while (n_requests < 1600 + plan.size())
        begin
            if (phase == 0 && n_requests > 560)
            begin
                // Sender quiet, receiver eager
                phase    = 1;
                src_idle = 82;
                snk_idle = 22;
                drain_responses();
            end
            else if (phase == 1 && n_requests > 1100)
            begin
                // Back-to-back in both directions
                phase    = 2;
                src_idle = 0;
                snk_idle = 0;
                drain_responses();
            end

            kind = $urandom_range(0, 99);
            cnt  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 5);
            len  = ((cnt > DEPTH) ? DEPTH : cnt) + $urandom_range(0, 1);
            if (kind < 40)
            begin
                // Write transfer, sometimes missing the start-sent event
                r                = rand_req();
                r.req_type       = REQ_START;
                r.address_byte[0] = 1'b0;
                r.transfer_count = 5'(cnt);
                issue(r, 1'b0, '0);
                if ($urandom_range(0, 9) != 0)
                    issue(bus_event(ST_START_SENT), 1'b0, '0);
                nack = 1'b0;
                for (int k = 0; k <= len && !nack; k++)
                begin
                    nack = ($urandom_range(0, 29) == 0);
                    if (nack)
                        r = bus_event((k == 0) ? ST_MT_SLA_NACK : ST_MT_DATA_NACK);
                    else
                        r = bus_event((k == 0) ? ST_MT_SLA_ACK : ST_MT_DATA_ACK);
                    if (r.bus_event_flag && !nack && seq_left > 0)
                        n_sent++;
                    issue(r, 1'b0, '0);
                end
            end
            else if (kind < 75)
            begin
                // Read transfer: address ACK, then data with NACK on the last
                r                = rand_req();
                r.req_type       = REQ_START;
                r.address_byte[0] = 1'b1;
                r.transfer_count = 5'(cnt);
                issue(r, 1'b0, '0);
                issue(bus_event(ST_START_SENT), 1'b0, '0);
                issue(bus_event(ST_MR_SLA_ACK), 1'b0, '0);
                for (int k = 0; k < len; k++)
                begin
                    r = bus_event((k == len - 1) ? ST_MR_DATA_NACK : ST_MR_DATA_ACK);
                    if (r.bus_event_flag)
                        n_received++;
                    issue(r, 1'b0, '0);
                end
            end
            else if (kind < 88)
            begin
                // Buffer load or read-back
                r          = rand_req();
                r.req_type = ($urandom_range(0, 1) != 0) ? REQ_LOAD : REQ_READ;
                issue(r, 1'b0, '0);
            end
            else
            begin
                // Noise: any kind, any raw status
                issue(rand_req(), 1'b0, '0);
            end
        end

        // Let the pipeline empty out
        drain_responses();
        repeat (10) @(posedge clk);

        $display("Covered %0d requests and %0d responses: %0d stops, %0d bytes sent,",
                 n_requests, n_responses, n_stops, n_sent);
        $display("%0d bytes received, across three idling mixes.", n_received);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
